### rtl/core/lrth_pkg.sv
// Shared types and constants for the LRU table handle cache.
package lrth_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = 6;
    localparam int AGE_W       = 6;
    localparam int CNT_W       = 7;
    localparam int CAP_W       = 5;
    localparam int SLOT_W      = 4;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [AGE_W-1:0] t_age;
    typedef logic [CNT_W-1:0] t_cnt;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic look;
        logic commit;
        logic do_hit;
        logic do_ins;
        logic evict;
        t_key key;
        t_age hit_age;
        t_age last_age;
    } t_cmd;

    // carried from cell to cell along the row
    typedef struct packed {
        logic free_seen;
        logic hit;
        logic victim;
        t_idx free_slot;
        t_idx hit_slot;
        t_idx vic_slot;
        t_age hit_age;
        t_key vic_key;
    } t_link;

    typedef struct packed {
        logic valid;
        t_age age;
    } t_cell_st;

endpackage

### rtl/core/lrth_if.sv
// Valid/ready channel interfaces for lookup requests and results.
interface lrth_in_if;
    import lrth_pkg::*;
    logic valid;
    logic ready;
    t_key key;
    logic open_ok;

    modport source (output valid, output key, output open_ok, input ready);
    modport sink   (input valid, input key, input open_ok, output ready);
endinterface

interface lrth_out_if;
    import lrth_pkg::*;
    logic                valid;
    logic                ready;
    logic                hit;
    logic                status;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    t_key                evicted_key;

    modport source (output valid, output hit, output status, output slot,
                    output evicted, output evicted_key, input ready);
    modport sink   (input valid, input hit, input status, input slot,
                    input evicted, input evicted_key, output ready);
endinterface

### rtl/core/lrth_cell.sv
// One cache entry: key, valid, recency rank, and its link in the row.
module lrth_cell
    import lrth_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  t_link    i_link,
    output t_link    o_link,
    output t_cell_st o_st
);

    localparam t_idx MY_IDX = t_idx'(IDX);

    logic r_valid;
    t_age r_age;
    t_key r_key;
    logic r_match;
    logic r_victim;

    logic w_first_free;
    logic w_sel;

    assign w_first_free = !r_valid && !i_link.free_seen;

    always_comb begin
        o_link           = i_link;
        o_link.free_seen = i_link.free_seen | !r_valid;
        if (w_first_free) begin
            o_link.free_slot = MY_IDX;
        end
        if (r_match) begin
            o_link.hit      = 1'b1;
            o_link.hit_slot = MY_IDX;
            o_link.hit_age  = r_age;
        end
        if (r_victim) begin
            o_link.victim   = 1'b1;
            o_link.vic_slot = MY_IDX;
            o_link.vic_key  = r_key;
        end
    end

    always_comb begin
        w_sel = 1'b0;
        if (i_cmd.do_hit) begin
            w_sel = r_match;
        end else if (i_cmd.do_ins) begin
            w_sel = i_cmd.evict ? r_victim : w_first_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_age    <= '0;
            r_match  <= 1'b0;
            r_victim <= 1'b0;
        end else begin
            if (i_cmd.look) begin
                r_match  <= r_valid && (r_key == i_cmd.key);
                r_victim <= r_valid && (r_age == i_cmd.last_age);
            end
            if (i_cmd.commit) begin
                if (w_sel) begin
                    r_valid <= 1'b1;
                    r_age   <= '0;
                end else if (r_valid) begin
                    // on a hit only the younger entries age; an insert ages all
                    if (i_cmd.do_ins || (i_cmd.do_hit && r_age < i_cmd.hit_age)) begin
                        r_age <= r_age + t_age'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && i_cmd.do_ins && w_sel) begin
            r_key <= i_cmd.key;
        end
    end

    assign o_st.valid = r_valid;
    assign o_st.age   = r_age;

endmodule

### rtl/core/lru_table_handle_cache_unit.sv
// Fully associative LRU cache of table handles built as a row of entry cells.
// Steps: the request beat is captured, the row compares keys in S_LOOK, and the result
// is registered in S_UPD; a new request is accepted only once the last one has committed.
// The update waits while an earlier result beat is still held at the output.
// Reset (synchronous, active low) empties every entry and sets capacity to ENTRIES.
module lru_table_handle_cache_unit
    import lrth_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    lrth_in_if.sink              i_in,
    lrth_out_if.source           o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    localparam t_cnt ENT_CNT = t_cnt'(ENTRIES);

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_cnt       r_cap;
    t_cnt       r_count;
    t_key       r_key;
    logic       r_open_ok;
    logic       r_out_valid;
    logic       r_hit;
    logic       r_status;
    logic [SLOT_W-1:0] r_slot;
    logic       r_evicted;
    t_key       r_evicted_key;

    t_link    w_link [ENTRIES+1];
    t_cell_st w_st   [ENTRIES];
    t_link    w_end;
    t_cmd     w_cmd;
    t_cnt     w_eff_cap;
    t_cnt     w_cnt_m1;
    logic     w_commit;
    logic     w_do_ins;
    logic     w_evict;
    t_idx     w_slot;
    logic [ENTRIES-1:0] w_valid_vec;
    logic [ENTRIES-1:0] w_young_vec;

    assign w_link[0] = '0;
    assign w_end     = w_link[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lrth_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_st    (w_st[g])
        );
        assign w_valid_vec[g] = w_st[g].valid;
        assign w_young_vec[g] = w_st[g].valid && (w_st[g].age == '0);
    end

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = t_cnt'(1);
        end else if (r_cap > ENT_CNT) begin
            w_eff_cap = ENT_CNT;
        end else begin
            w_eff_cap = r_cap;
        end
    end

    assign w_cnt_m1 = r_count - t_cnt'(1);
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || o_out.ready);
    assign w_do_ins = !w_end.hit && r_open_ok;
    assign w_evict  = w_do_ins && (r_count >= w_eff_cap);

    always_comb begin
        w_cmd.look     = (r_state == S_LOOK);
        w_cmd.commit   = w_commit;
        w_cmd.do_hit   = w_end.hit;
        w_cmd.do_ins   = w_do_ins;
        w_cmd.evict    = w_evict;
        w_cmd.key      = r_key;
        w_cmd.hit_age  = w_end.hit_age;
        w_cmd.last_age = w_cnt_m1[AGE_W-1:0];
    end

    always_comb begin
        if (w_end.hit) begin
            w_slot = w_end.hit_slot;
        end else if (w_evict) begin
            w_slot = w_end.vic_slot;
        end else if (w_do_ins) begin
            w_slot = w_end.free_slot;
        end else begin
            w_slot = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_LOOK;
            S_LOOK: n_state = S_UPD;
            S_UPD:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= ENT_CNT;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= t_cnt'(i_cfg_wdata);
            end
            if (w_commit && w_do_ins && !w_evict) begin
                r_count <= r_count + t_cnt'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_key     <= i_in.key;
            r_open_ok <= i_in.open_ok;
        end
        if (w_commit) begin
            r_hit         <= w_end.hit;
            r_status      <= !w_end.hit && !r_open_ok;
            r_slot        <= w_slot[SLOT_W-1:0];
            r_evicted     <= w_evict;
            r_evicted_key <= w_evict ? w_end.vic_key : '0;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_hit;
    assign o_out.status      = r_status;
    assign o_out.slot        = r_slot;
    assign o_out.evicted     = r_evicted;
    assign o_out.evicted_key = r_evicted_key;

    a_count_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_cnt'($countones(w_valid_vec)) == r_count)
        else $error("entry count out of step with valid entries");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ENT_CNT)
        else $error("entry count above table size");

    a_one_most_recent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> $onehot(w_young_vec))
        else $error("recency ranks lost uniqueness at the head");

    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_evicted) |-> (!r_hit && !r_status))
        else $error("eviction reported on a hit or failed open");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_status |-> (r_slot == '0 && r_evicted_key == '0))
        else $error("failed open carries slot or key");

endmodule
